[hw/rtl/rau_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the rational arithmetic unit.
// Used by rau_ctrl, rau_dpath, the top level and its checker; no dependencies.

package rau_pkg;

    // Field and word widths
    localparam int FIELD_W      = 16;
    localparam int CMD_W        = 4;
    localparam int PROD_W       = 2 * FIELD_W;
    localparam int NUM_W        = PROD_W + 1;
    localparam int MAG_W        = PROD_W;
    localparam int DEN_W        = 31;
    localparam int ERR_W        = 2;
    localparam int SHIFT_W      = $clog2(MAG_W);
    localparam int S_TDATA_W    = 4 * FIELD_W;
    localparam int S_TUSER_W    = CMD_W;
    localparam int M_TDATA_USED = NUM_W + DEN_W + 1;
    localparam int M_TDATA_W    = ((M_TDATA_USED + 7) / 8) * 8;
    localparam int M_TUSER_W    = ERR_W;

    localparam int DEFAULT_OPERAND_WIDTH = 16;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_ADD = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 4'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 4'd3;
    localparam logic [CMD_W-1:0] CMD_EQ  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_NE  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_LT  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_GT  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_LE  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_GE  = 4'd9;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_ZERO_DEN = 2'd1;
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO = 2'd2;

    // Which cross product the shared multiplier forms
    typedef enum logic [1:0] {
        MUL_SEL_P0,
        MUL_SEL_P1,
        MUL_SEL_P2
    } mul_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     gcd_init;
        logic     gcd_step;
        logic     div_init;
        logic     div_step;
        logic     out_load;
    } rau_ctl_t;

    // Datapath to controller
    typedef struct packed {
        logic arith_ok;
        logic u_zero;
        logic out_free;
    } rau_sts_t;

endpackage

[hw/rtl/rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Top level of the rational arithmetic unit: joins rau_ctrl and rau_dpath.
// Depends on rau_pkg.
//
//  Channel  Dir  Width     Contents
//  s_axis   in   64 + 4    tdata: a_num, a_den, b_num, b_den; tuser: cmd
//  m_axis   out  72 + 2    tdata: res_num, res_den, cmp_flag, pad; tuser: err
//
// One item is in flight at a time. Compares and error cases go from accept to
// result through the product, prep and finish states. Add, sub, mul and div
// also run the data-dependent binary GCD loop and the bit-serial quotient loop;
// the shared 16 x 16 multiplier forms the three cross products first. A
// finished result waits in the output register while the next beat is
// accepted. Reset clears the sequencer and the output valid.

module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // a_num [15:0], a_den [31:16], b_num [47:32], b_den [63:48]
    input  logic [rau_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // cmd [3:0]
    input  logic [rau_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // res_num [32:0], res_den [63:33], cmp_flag [64], zero pad [71:65]
    output logic [rau_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // err [1:0]
    output logic [rau_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
    import rau_pkg::*;

    rau_ctl_t ctl;
    rau_sts_t sts;

    // Sequencer
    rau_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .ctl     (ctl)
    );

    // Arithmetic and output register
    rau_dpath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .ctl      (ctl),
        .sts      (sts),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

endmodule

[hw/rtl/rau_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer for the rational arithmetic unit: products, GCD loop, quotient loop.
// Depends on rau_pkg for the command and status structs.

module rau_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  rau_pkg::rau_sts_t  sts,
    output rau_pkg::rau_ctl_t  ctl
);
    import rau_pkg::*;

    localparam int DIV_STEPS = MAG_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_PREP,
        ST_GCD,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        ctl.mul_sel = MUL_SEL_P0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_ready = 1'b1;
                if (s_valid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_SEL_P0;
                state_next  = ST_MUL1;
            end
            ST_MUL1:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_SEL_P1;
                state_next  = ST_MUL2;
            end
            ST_MUL2:
            begin
                ctl.mul_en  = 1'b1;
                ctl.mul_sel = MUL_SEL_P2;
                state_next  = ST_PREP;
            end
            ST_PREP:
            begin
                if (sts.arith_ok)
                begin
                    ctl.gcd_init = 1'b1;
                    state_next   = ST_GCD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_GCD:
            begin
                // u reaching zero leaves the gcd in v with the shared twos taken out (k counts them)
                if (sts.u_zero)
                begin
                    ctl.div_init = 1'b1;
                    cnt_next     = '0;
                    state_next   = ST_DIV;
                end
                else
                begin
                    ctl.gcd_step = 1'b1;
                end
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold the result until the output register frees up
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[hw/rtl/rau_dpath.sv]
`timescale 1ns / 1ps
// Datapath: operand registers, shared multiplier, binary GCD, two quotient
// lanes and the output register. Depends on rau_pkg.

module rau_dpath #(
    parameter int OPERAND_WIDTH = rau_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [rau_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [rau_pkg::S_TUSER_W-1:0]    s_tuser,
    input  rau_pkg::rau_ctl_t                ctl,
    output rau_pkg::rau_sts_t                sts,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rau_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [rau_pkg::M_TUSER_W-1:0]    m_tuser
);
    import rau_pkg::*;

    localparam int OW_EFF    = (OPERAND_WIDTH > FIELD_W) ? FIELD_W : OPERAND_WIDTH;
    localparam int NARROW_SH = FIELD_W - OW_EFF;
    localparam int PAD_W     = M_TDATA_W - M_TDATA_USED;

    // Keep the low OW_EFF bits and sign-extend them back to the field width
    function automatic logic signed [FIELD_W-1:0] narrow(input logic [FIELD_W-1:0] x);
        logic [FIELD_W-1:0] t;
        t = x << NARROW_SH;
        return $signed(t) >>> NARROW_SH;
    endfunction

    // One restoring division step: returns {remainder, quotient/dividend}
    function automatic logic [2*MAG_W-1:0] div_iter(
        input logic [MAG_W-1:0] rem,
        input logic [MAG_W-1:0] q,
        input logic [MAG_W-1:0] d
    );
        logic [MAG_W:0] sh;
        logic           bit_q;
        sh    = {rem, q[MAG_W-1]};
        bit_q = (sh >= {1'b0, d});
        if (bit_q)
        begin
            sh = sh - {1'b0, d};
        end
        return {sh[MAG_W-1:0], q[MAG_W-2:0], bit_q};
    endfunction

    logic [CMD_W-1:0]          cmd_reg;
    logic signed [FIELD_W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PROD_W-1:0]  p0_reg, p1_reg, p2_reg;
    logic [MAG_W-1:0]          u_reg, v_reg, u_next, v_next;
    logic [SHIFT_W-1:0]        k_reg, k_next;
    logic                      neg_reg;
    logic [MAG_W-1:0]          qn_reg, rn_reg, qd_reg, rd_reg, dv_reg;
    logic [NUM_W-1:0]          num_out_reg;
    logic [DEN_W-1:0]          den_out_reg;
    logic                      flag_out_reg;
    logic [ERR_W-1:0]          err_out_reg;
    logic                      m_valid_reg;

    logic signed [FIELD_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [NUM_W-1:0]   num_ext, p0_ext, p1_ext;
    logic [NUM_W-1:0]          num_abs;
    logic [MAG_W-1:0]          den_abs;
    logic                      is_arith, div_zero, den_zero, operands_eq, flag;
    logic [ERR_W-1:0]          err_code;
    logic [2*MAG_W-1:0]        lane_n, lane_d;

    // Pick the multiplier operands for the current cross product
    always_comb
    begin
        case (ctl.mul_sel)
            MUL_SEL_P0:
            begin
                mul_a = an_reg;
                mul_b = (cmd_reg == CMD_MUL) ? bn_reg : bd_reg;
            end
            MUL_SEL_P1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            MUL_SEL_P2:
            begin
                mul_a = ad_reg;
                mul_b = (cmd_reg == CMD_DIV) ? bn_reg : bd_reg;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Form the unreduced numerator and the magnitudes
    assign p0_ext = {p0_reg[PROD_W-1], p0_reg};
    assign p1_ext = {p1_reg[PROD_W-1], p1_reg};

    always_comb
    begin
        case (cmd_reg)
            CMD_ADD: num_ext = p0_ext + p1_ext;
            CMD_SUB: num_ext = p0_ext - p1_ext;
            default: num_ext = p0_ext;
        endcase
    end

    assign num_abs = num_ext[NUM_W-1] ? (NUM_W'(0) - num_ext) : num_ext;
    assign den_abs = p2_reg[PROD_W-1] ? (MAG_W'(0) - p2_reg) : p2_reg;

    // Classify the command and its exceptions
    assign is_arith = (cmd_reg == CMD_ADD) || (cmd_reg == CMD_SUB)
                   || (cmd_reg == CMD_MUL) || (cmd_reg == CMD_DIV);
    assign div_zero = (cmd_reg == CMD_DIV) && (bn_reg == '0);
    assign den_zero = (p2_reg == '0);

    assign operands_eq = (an_reg == bn_reg) && (ad_reg == bd_reg);

    // Flag: EQ/NE match fields, LT..GE use p0 = a_num*b_den, p1 = b_num*a_den
    always_comb
    begin
        case (cmd_reg)
            CMD_EQ:  flag = operands_eq;
            CMD_NE:  flag = !operands_eq;
            CMD_LT:  flag = (p0_reg < p1_reg);
            CMD_GT:  flag = (p1_reg < p0_reg);
            CMD_LE:  flag = !(p1_reg < p0_reg);
            CMD_GE:  flag = !(p0_reg < p1_reg);
            default: flag = 1'b0;
        endcase
    end

    always_comb
    begin
        if (div_zero)
        begin
            err_code = ERR_DIV_ZERO;
        end
        else if (is_arith && den_zero)
        begin
            err_code = ERR_ZERO_DEN;
        end
        else
        begin
            err_code = ERR_OK;
        end
    end

    // Binary GCD step
    always_comb
    begin
        u_next = u_reg;
        v_next = v_reg;
        k_next = k_reg;
        if (!u_reg[0] && !v_reg[0])
        begin
            u_next = u_reg >> 1;
            v_next = v_reg >> 1;
            k_next = k_reg + 1'b1;
        end
        else if (!u_reg[0])
        begin
            u_next = u_reg >> 1;
        end
        else if (!v_reg[0])
        begin
            v_next = v_reg >> 1;
        end
        else if (u_reg >= v_reg)
        begin
            u_next = (u_reg - v_reg) >> 1;
        end
        else
        begin
            v_next = (v_reg - u_reg) >> 1;
        end
    end

    assign lane_n = div_iter(rn_reg, qn_reg, dv_reg);
    assign lane_d = div_iter(rd_reg, qd_reg, dv_reg);

    // Operand, product, GCD and quotient registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= s_tuser[CMD_W-1:0];
            an_reg  <= narrow(s_tdata[FIELD_W-1:0]);
            ad_reg  <= narrow(s_tdata[2*FIELD_W-1:FIELD_W]);
            bn_reg  <= narrow(s_tdata[3*FIELD_W-1:2*FIELD_W]);
            bd_reg  <= narrow(s_tdata[4*FIELD_W-1:3*FIELD_W]);
        end
        if (ctl.mul_en)
        begin
            case (ctl.mul_sel)
                MUL_SEL_P0: p0_reg <= prod;
                MUL_SEL_P1: p1_reg <= prod;
                MUL_SEL_P2: p2_reg <= prod;
                default:    p0_reg <= prod;
            endcase
        end
        if (ctl.gcd_init)
        begin
            u_reg   <= num_abs[MAG_W-1:0];
            v_reg   <= den_abs;
            k_reg   <= '0;
            neg_reg <= num_ext[NUM_W-1] ^ p2_reg[PROD_W-1];
            qn_reg  <= num_abs[MAG_W-1:0];
            qd_reg  <= den_abs;
        end
        else if (ctl.gcd_step)
        begin
            u_reg <= u_next;
            v_reg <= v_next;
            k_reg <= k_next;
        end
        if (ctl.div_init)
        begin
            dv_reg <= v_reg << k_reg;
            rn_reg <= '0;
            rd_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            rn_reg <= lane_n[2*MAG_W-1:MAG_W];
            qn_reg <= lane_n[MAG_W-1:0];
            rd_reg <= lane_d[2*MAG_W-1:MAG_W];
            qd_reg <= lane_d[MAG_W-1:0];
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            if (sts.arith_ok)
            begin
                num_out_reg  <= neg_reg ? (NUM_W'(0) - {1'b0, qn_reg}) : {1'b0, qn_reg};
                den_out_reg  <= qd_reg[DEN_W-1:0];
                flag_out_reg <= 1'b0;
                err_out_reg  <= ERR_OK;
            end
            else
            begin
                num_out_reg  <= '0;
                den_out_reg  <= DEN_W'(1);
                flag_out_reg <= flag;
                err_out_reg  <= err_code;
            end
        end
    end

    // Output valid: set on load, drop once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.arith_ok = is_arith && !div_zero && !den_zero;
    assign sts.u_zero   = (u_reg == '0);
    assign sts.out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, flag_out_reg, den_out_reg, num_out_reg};
    assign m_tuser  = err_out_reg;

endmodule

[hw/rtl/rau_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit.

module rau_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rau_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    input logic [rau_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
    import rau_pkg::*;

    localparam int DEN_LO = NUM_W;
    localparam int DEN_HI = NUM_W + DEN_W - 1;
    localparam int FLAG_B = NUM_W + DEN_W;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // Only one item in flight: input closes right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted again before result formed");

    // Reduced denominator is never zero
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[DEN_HI:DEN_LO] != '0)
        else $error("zero denominator on output");

    // Errors and set flags come with 0/1 and a known error code
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ERR_OK || m_axis_tdata[FLAG_B]) |->
            m_axis_tdata[NUM_W-1:0] == '0 && m_axis_tdata[DEN_HI:DEN_LO] == DEN_W'(1)
            && (m_axis_tuser == ERR_OK || m_axis_tuser == ERR_ZERO_DEN
                || m_axis_tuser == ERR_DIV_ZERO))
        else $error("error or flag beat without a 0/1 result");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
